@@ hdl/nccw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and codes of the nearest-center weighted cost block.
// No dependencies; every other file imports this package.
package nccw_pkg;

  localparam int COORD_W  = 16;
  localparam int WEIGHT_W = 16;
  localparam int SQ_W     = 32;
  localparam int ACC_W    = 36;
  localparam int WD_W     = 52;
  localparam int TOT_W    = 64;
  localparam int CIDX_W   = 3;
  localparam int DIDX_W   = 4;
  localparam int NCFG_W   = 4;
  localparam int NDIM_W   = 5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [NCFG_W-1:0] CENTERS_RST = 4'd8;
  localparam logic [NDIM_W-1:0] DIMS_RST    = 5'd16;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_POINT = 1'b1
  } nccw_cmd_e;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_ACTIVE_CENTERS = 1'b0,
    REG_ACTIVE_DIMS    = 1'b1
  } nccw_reg_e;

  typedef struct packed {
    logic start;
    logic commit;
    logic last;
  } nccw_cost_ctl_t;

endpackage

@@ hdl/nccw_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
// Depends on nccw_pkg for field widths.
interface nccw_in_if;
  import nccw_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [CIDX_W-1:0]          center_index;
  logic [DIDX_W-1:0]          coord_index;
  logic signed [COORD_W-1:0]  coord_value;
  logic [WEIGHT_W-1:0]        point_weight;
  logic                       last_point;

  modport source (output valid, cmd, center_index, coord_index, coord_value,
                  point_weight, last_point, input ready);
  modport sink   (input valid, cmd, center_index, coord_index, coord_value,
                  point_weight, last_point, output ready);
endinterface

interface nccw_out_if;
  import nccw_pkg::*;
  logic                valid;
  logic                ready;
  logic [CIDX_W-1:0]   nearest_index;
  logic [ACC_W-1:0]    min_distance;
  logic [WD_W-1:0]     weighted_distance;
  logic [TOT_W-1:0]    total_cost;
  logic                set_end;

  modport source (output valid, nearest_index, min_distance, weighted_distance,
                  total_cost, set_end, input ready);
  modport sink   (input valid, nearest_index, min_distance, weighted_distance,
                  total_cost, set_end, output ready);
endinterface

@@ hdl/nccw_center_mem.sv @@
`timescale 1ns / 1ps
// Center coordinate store: one write port, one registered read port.
// Depends on nccw_pkg for the coordinate width.
module nccw_center_mem import nccw_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic signed [COORD_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic signed [COORD_W-1:0] rdata_o
);

  logic signed [COORD_W-1:0] mem_q [DEPTH];
  logic signed [COORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/nccw_sq_unit.sv @@
`timescale 1ns / 1ps
// Shared difference-and-square unit, one registered stage.
// Depends on nccw_pkg for widths.
module nccw_sq_unit import nccw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      active_i,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] c_i,
  output logic [SQ_W-1:0]           sq_o
);

  logic signed [COORD_W:0] diff;
  logic [COORD_W:0]        neg;
  logic [COORD_W-1:0]      mag;
  logic [SQ_W-1:0]         sq_q;

  always_comb begin
    diff = {x_i[COORD_W-1], x_i} - {c_i[COORD_W-1], c_i};
    neg  = -diff;
    // |diff| never exceeds 2^16-1, so the low bits hold it
    mag  = diff[COORD_W] ? neg[COORD_W-1:0] : diff[COORD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= active_i ? (SQ_W'(mag) * SQ_W'(mag)) : '0;
    end
  end

  assign sq_o = sq_q;

endmodule

@@ hdl/nccw_cost_unit.sv @@
`timescale 1ns / 1ps
// Weighting multiply and saturating running total of weighted distances.
// Depends on nccw_pkg for widths and the control struct.
module nccw_cost_unit import nccw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nccw_cost_ctl_t      ctl_i,
  input  logic [ACC_W-1:0]    best_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  output logic [WD_W-1:0]     wd_o,
  output logic [TOT_W-1:0]    total_o,
  output logic                done_o
);

  logic [WD_W-1:0]  wd_q;
  logic [TOT_W-1:0] tot_q;
  logic [TOT_W-1:0] total_q;
  logic             p1_q;
  logic             done_q;
  logic [TOT_W:0]   sum;

  assign sum = {1'b0, total_q} + (TOT_W + 1)'(wd_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      wd_q <= WD_W'(best_i) * WD_W'(weight_i);
    end
    if (p1_q) begin
      tot_q <= sum[TOT_W] ? '1 : sum[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q    <= 1'b0;
      done_q  <= 1'b0;
      total_q <= '0;
    end else begin
      p1_q <= ctl_i.start;
      if (p1_q) begin
        done_q <= 1'b1;
      end else if (ctl_i.commit) begin
        done_q  <= 1'b0;
        total_q <= ctl_i.last ? '0 : tot_q;
      end
    end
  end

  assign wd_o    = wd_q;
  assign total_o = tot_q;
  assign done_o  = done_q;

endmodule

@@ hdl/nearest_center_weighted_cost_core.sv @@
`timescale 1ns / 1ps
// Nearest-center search with weighted cost. A center-load transaction leaves ready high.
// A point-coordinate transaction holds ready low while it reads every center slot (one read
// per center slot), drains the 3-stage pipeline and sees it empty; only then is the next taken.
// A final coordinate adds the weighting multiply and total before its result is valid; the
// result comes later while the previous result is held.
// rst_ni async, active low: clears control, accumulators, total, registers (8, 16).
module nearest_center_weighted_cost_core import nccw_pkg::*; #(
  parameter int MAX_CENTERS = 8,
  parameter int MAX_DIMS    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nccw_in_if.sink           in_if,
  nccw_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CIW   = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int CNW   = $clog2(MAX_CENTERS + 1);
  localparam int DIW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int NDW   = $clog2(MAX_DIMS + 1);
  localparam int DEPTH = MAX_CENTERS * MAX_DIMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_COST
  } state_e;

  // ------------------------------------------------------------------
  // Configuration registers (APB, no wait states)
  // ------------------------------------------------------------------
  logic [NCFG_W-1:0] act_centers_q;
  logic [NDIM_W-1:0] act_dims_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_centers_q <= CENTERS_RST;
      act_dims_q    <= DIMS_RST;
    end else if (cfg_we) begin
      unique case (nccw_reg_e'(paddr[2]))
        REG_ACTIVE_CENTERS: act_centers_q <= pwdata[NCFG_W-1:0];
        REG_ACTIVE_DIMS:    act_dims_q    <= pwdata[NDIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (nccw_reg_e'(paddr[2]))
      REG_ACTIVE_CENTERS: prdata = APB_DW'(act_centers_q);
      REG_ACTIVE_DIMS:    prdata = APB_DW'(act_dims_q);
      default:            prdata = '0;
    endcase
  end

  // Clamp the registers to the usable range
  logic [CNW-1:0] nc;
  logic [NDW-1:0] nd;

  always_comb begin
    if (act_centers_q == '0)                 nc = CNW'(1);
    else if (32'(act_centers_q) > MAX_CENTERS) nc = CNW'(MAX_CENTERS);
    else                                     nc = CNW'(act_centers_q);
    if (act_dims_q == '0)                    nd = NDW'(1);
    else if (32'(act_dims_q) > MAX_DIMS)     nd = NDW'(MAX_DIMS);
    else                                     nd = NDW'(act_dims_q);
  end

  // ------------------------------------------------------------------
  // Input decode: loads write the store at once, points start a pass
  // ------------------------------------------------------------------
  state_e state_q;
  logic   in_acc, in_range, load_we, point_start, is_final;
  logic [AW-1:0] waddr, raddr;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid & in_if.ready;
  assign in_range    = 32'(in_if.coord_index) < 32'(nd);
  assign load_we     = in_acc & (in_if.cmd == CMD_LOAD) & in_range &
                       (32'(in_if.center_index) < MAX_CENTERS);
  assign point_start = in_acc & (in_if.cmd == CMD_POINT) & in_range;
  assign is_final    = 32'(in_if.coord_index) == (32'(nd) - 1);
  assign waddr       = AW'(32'(in_if.center_index) * MAX_DIMS + 32'(in_if.coord_index));

  // ------------------------------------------------------------------
  // Pass sequencer and pipeline
  //   issue : read center slot cnt_q, coordinate didx_q
  //   s1    : square unit forms (x - c)^2
  //   s2    : add to head of accumulator ring, saturate, rotate
  //   s3    : running minimum over active slots
  // ------------------------------------------------------------------
  logic signed [COORD_W-1:0] x_q;
  logic [DIW-1:0]            didx_q;
  logic [WEIGHT_W-1:0]       weight_q;
  logic                      last_q, final_q;
  logic [CNW-1:0]            cnt_q;
  logic                      v1_q, v2_q, v3_q;
  logic                      act1_q, act2_q, act3_q;
  logic [CIW-1:0]            c1_q, c2_q, c3_q;
  logic [ACC_W-1:0]          sum3_q;
  logic [ACC_W-1:0]          best_q;
  logic [CIW-1:0]            bidx_q;
  logic [ACC_W-1:0]          acc_q [MAX_CENTERS];

  logic                      issue, run_done, out_free;
  logic signed [COORD_W-1:0] rd_data;
  logic [SQ_W-1:0]           sq;
  logic [ACC_W:0]            sum;
  logic [ACC_W-1:0]          sum_sat;

  assign issue    = (state_q == ST_RUN) && (32'(cnt_q) < MAX_CENTERS);
  assign raddr    = AW'(32'(cnt_q) * MAX_DIMS + 32'(didx_q));
  assign run_done = (state_q == ST_RUN) && (32'(cnt_q) == MAX_CENTERS) &&
                    !v1_q && !v2_q && !v3_q;
  assign sum      = {1'b0, acc_q[0]} + (ACC_W + 1)'(sq);
  assign sum_sat  = sum[ACC_W] ? '1 : sum[ACC_W-1:0];

  nccw_center_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (waddr),
    .wdata_i (in_if.coord_value),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  nccw_sq_unit u_sq (
    .clk_i    (clk_i),
    .en_i     (v1_q),
    .active_i (act1_q),
    .x_i      (x_q),
    .c_i      (rd_data),
    .sq_o     (sq)
  );

  // ------------------------------------------------------------------
  // Cost unit: weight multiply, saturating total
  // ------------------------------------------------------------------
  nccw_cost_ctl_t      cost_ctl;
  logic [WD_W-1:0]     cost_wd;
  logic [TOT_W-1:0]    cost_total;
  logic                cost_done;

  assign out_free        = !out_if.valid || out_if.ready;
  assign cost_ctl.start  = run_done & final_q;
  assign cost_ctl.commit = (state_q == ST_COST) & cost_done & out_free;
  assign cost_ctl.last   = last_q;

  nccw_cost_unit u_cost (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (cost_ctl),
    .best_i   (best_q),
    .weight_i (weight_q),
    .wd_o     (cost_wd),
    .total_o  (cost_total),
    .done_o   (cost_done)
  );

  // Payload holds for the point in flight; no reset needed
  always_ff @(posedge clk_i) begin
    if (point_start) begin
      x_q      <= in_if.coord_value;
      didx_q   <= DIW'(in_if.coord_index);
      weight_q <= in_if.point_weight;
      last_q   <= in_if.last_point;
      final_q  <= is_final;
    end
    if (issue) begin
      c1_q   <= CIW'(cnt_q);
      act1_q <= cnt_q < nc;
    end
    c2_q   <= c1_q;
    act2_q <= act1_q;
    c3_q   <= c2_q;
    act3_q <= act2_q;
    if (v2_q) begin
      sum3_q <= sum_sat;
    end
    // strict compare: a tie keeps the lower slot
    if (v3_q && act3_q && ((c3_q == '0) || (sum3_q < best_q))) begin
      best_q <= sum3_q;
      bidx_q <= c3_q;
    end
  end

  // Sequencer state, accumulator ring and result register
  logic              out_valid_q;
  logic [CIDX_W-1:0] out_idx_q;
  logic [ACC_W-1:0]  out_min_q;
  logic [WD_W-1:0]   out_wd_q;
  logic [TOT_W-1:0]  out_tot_q;
  logic              out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_min_q   <= '0;
      out_wd_q    <= '0;
      out_tot_q   <= '0;
      out_end_q   <= 1'b0;
      for (int i = 0; i < MAX_CENTERS; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (issue) begin
        cnt_q <= cnt_q + CNW'(1);
      end

      // Rotate the ring once per slot; a final coordinate leaves it cleared
      if (v2_q) begin
        for (int i = 0; i < MAX_CENTERS - 1; i++) begin
          acc_q[i] <= acc_q[i+1];
        end
        acc_q[MAX_CENTERS-1] <= final_q ? '0 : sum_sat;
      end

      // Drop the result once taken, unless a new one replaces it
      if (out_if.valid && out_if.ready && !cost_ctl.commit) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (point_start) begin
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (run_done) begin
            state_q <= final_q ? ST_COST : ST_IDLE;
          end
        end
        ST_COST: begin
          // hold until the total is ready and the result slot is free
          if (cost_ctl.commit) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= CIDX_W'(bidx_q);
            out_min_q   <= best_q;
            out_wd_q    <= cost_wd;
            out_tot_q   <= cost_total;
            out_end_q   <= last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid             = out_valid_q;
  assign out_if.nearest_index     = out_idx_q;
  assign out_if.min_distance      = out_min_q;
  assign out_if.weighted_distance = out_wd_q;
  assign out_if.total_cost        = out_tot_q;
  assign out_if.set_end           = out_end_q;

endmodule

@@ hdl/nccw_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the nearest-center core, bound to the top level.
// Depends on nccw_pkg and nearest_center_weighted_cost_core.
module nccw_checker import nccw_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CIDX_W-1:0] nearest_index,
  input logic [ACC_W-1:0]  min_distance,
  input logic [WD_W-1:0]   weighted_distance,
  input logic [TOT_W-1:0]  total_cost,
  input logic              set_end
);

  // A center load never stalls the input side
  a_load_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && (in_cmd == CMD_LOAD)) |=> in_ready)
    else $error("input stalled after a center load");

  // A new result only appears while a point is in flight
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the input side was idle");

  // The total includes the current weighted distance
  a_total_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (total_cost >= TOT_W'(weighted_distance)))
    else $error("total below weighted distance");

  // Zero distance weighs zero
  a_zero_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (min_distance == '0)) |-> (weighted_distance == '0))
    else $error("nonzero weighted distance for zero distance");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(nearest_index) &&
      $stable(min_distance) && $stable(weighted_distance) &&
      $stable(total_cost) && $stable(set_end)))
    else $error("stalled result changed");

endmodule

bind nearest_center_weighted_cost_core nccw_checker u_nccw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .in_cmd            (in_if.cmd),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .nearest_index     (out_if.nearest_index),
  .min_distance      (out_if.min_distance),
  .weighted_distance (out_if.weighted_distance),
  .total_cost        (out_if.total_cost),
  .set_end           (out_if.set_end)
);

@@ verif/nccw_cost_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the nearest-center weighted cost core: watches both channels and
// the APB port, predicts each result and compares it. Depends on nccw_pkg and nccw_if.
module nccw_cost_checker import nccw_pkg::*; #(
  parameter int MAX_CENTERS = 8,
  parameter int MAX_DIMS    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nccw_in_if                in_mon,
  nccw_out_if               out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic [APB_DW-1:0] prdata,
  input  logic              pready,
  output int                mismatch_count_o,
  output int                results_pending_o
);

  localparam logic [ACC_W-1:0] ACC_SAT = '1;

  typedef struct packed {
    logic [CIDX_W-1:0] nearest_index;
    logic [ACC_W-1:0]  min_distance;
    logic [WD_W-1:0]   weighted_distance;
    logic [TOT_W-1:0]  total_cost;
    logic              set_end;
  } cost_result_t;

  logic signed [COORD_W-1:0] center_mem [MAX_CENTERS][MAX_DIMS];
  logic [ACC_W-1:0]          dist_acc [MAX_CENTERS];
  logic [TOT_W-1:0]          cost_sum;
  logic [NCFG_W-1:0]         centers_reg;
  logic [NDIM_W-1:0]         dims_reg;
  cost_result_t              expected_assignments [$];
  int                        mismatches = 0;
  int                        pending = 0;

  assign mismatch_count_o  = mismatches;
  assign results_pending_o = pending;

  function automatic int clamp_count(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, what, exp_v, act_v);
  endfunction

  // Fold one accepted item into the center store or the distance sums; on a
  // point's final coordinate, queue the nearest center and the running cost.
  task automatic predict_assignment();
    int               nc, nd, c, d, best;
    logic [63:0]      mag, sum, wd;
    logic [ACC_W-1:0] best_d;
    cost_result_t     r;
    nc = clamp_count(int'(centers_reg), MAX_CENTERS);
    nd = clamp_count(int'(dims_reg), MAX_DIMS);
    if (int'(in_mon.coord_index) >= nd) return;
    if (in_mon.cmd == CMD_LOAD) begin
      if (int'(in_mon.center_index) < MAX_CENTERS)
        center_mem[in_mon.center_index][in_mon.coord_index] = in_mon.coord_value;
      return;
    end
    for (c = 0; c < nc; c++) begin
      d   = int'($signed(in_mon.coord_value)) -
            int'($signed(center_mem[c][in_mon.coord_index]));
      mag = 64'((d < 0) ? -d : d);
      sum = 64'(dist_acc[c]) + mag * mag;
      dist_acc[c] = (sum > 64'(ACC_SAT)) ? ACC_SAT : sum[ACC_W-1:0];
    end
    if (int'(in_mon.coord_index) != nd - 1) return;
    best   = 0;
    best_d = dist_acc[0];
    for (c = 1; c < nc; c++) begin
      if (dist_acc[c] < best_d) begin
        best_d = dist_acc[c];
        best   = c;
      end
    end
    wd = 64'(best_d) * 64'(in_mon.point_weight);
    if (cost_sum > ~wd) cost_sum = '1;
    else cost_sum = cost_sum + wd;
    r.nearest_index     = CIDX_W'(best);
    r.min_distance      = best_d;
    r.weighted_distance = wd[WD_W-1:0];
    r.total_cost        = cost_sum;
    r.set_end           = in_mon.last_point;
    expected_assignments.push_back(r);
    foreach (dist_acc[i]) dist_acc[i] = '0;
    if (in_mon.last_point) cost_sum = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cost_result_t exp_r;
    logic [APB_DW-1:0] reg_val;
    if (!rst_ni) begin
      foreach (dist_acc[i]) dist_acc[i] = '0;
      cost_sum    = '0;
      centers_reg = CENTERS_RST;
      dims_reg    = DIMS_RST;
      expected_assignments.delete();
      pending = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_ACTIVE_CENTERS) centers_reg = pwdata[NCFG_W-1:0];
          else dims_reg = pwdata[NDIM_W-1:0];
        end else begin
          reg_val = (paddr[2] == REG_ACTIVE_CENTERS) ? APB_DW'(centers_reg) : APB_DW'(dims_reg);
          if (prdata !== reg_val) note_mismatch("register read", reg_val, prdata);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_assignments.size() == 0) begin
          note_mismatch("unexpected result, total_cost", '0, out_mon.total_cost);
        end else begin
          exp_r = expected_assignments.pop_front();
          if (out_mon.nearest_index !== exp_r.nearest_index)
            note_mismatch("nearest_index", exp_r.nearest_index, out_mon.nearest_index);
          if (out_mon.min_distance !== exp_r.min_distance)
            note_mismatch("min_distance", exp_r.min_distance, out_mon.min_distance);
          if (out_mon.weighted_distance !== exp_r.weighted_distance)
            note_mismatch("weighted_distance", exp_r.weighted_distance,
                          out_mon.weighted_distance);
          if (out_mon.total_cost !== exp_r.total_cost)
            note_mismatch("total_cost", exp_r.total_cost, out_mon.total_cost);
          if (out_mon.set_end !== exp_r.set_end)
            note_mismatch("set_end", exp_r.set_end, out_mon.set_end);
        end
      end
      if (in_mon.valid && in_mon.ready) predict_assignment();
      pending = expected_assignments.size();
    end
  end

endmodule

@@ verif/tb_nearest_center_weighted_cost_core.sv @@
`timescale 1ns / 1ps
// Top of the nearest-center weighted cost testbench: clock, reset, stimulus, APB
// configuration and verdict. Depends on nccw_pkg, nccw_if and nccw_cost_checker.
module tb_nearest_center_weighted_cost_core;
  import nccw_pkg::*;

  localparam int MAX_CENTERS   = 8;
  localparam int MAX_DIMS      = 16;
  localparam int RANDOM_ITEMS  = 480;
  // Wait once nothing is expected, long enough for a point coordinate, final or
  // not, to pass through the core.
  localparam int SETTLE_CYCLES = 2 * (MAX_CENTERS + 6);
  // Points streamed back to back at maximum distance and full weight
  localparam int STREAM_POINTS = 4;

  // Receiver stall patterns, each held for a random stretch
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  localparam logic [NCFG_W-1:0] EDGE_CENTERS [4] = '{4'd0, 4'd1, 4'd8, 4'd15};
  localparam logic [NDIM_W-1:0] EDGE_DIMS    [4] = '{5'd31, 5'd16, 5'd1, 5'd0};

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int results_pending;

  // Sender state: burst length left, idle cycles before the next burst
  bit fast_mode   = 1'b0;
  bit in_valid_hi = 1'b0;
  int burst_left  = 0;
  int gap_left    = 0;
  // Clamped register values as the stimulus sees them
  int act_centers = 8;
  int act_dims    = 16;

  nccw_in_if  in_ch ();
  nccw_out_if out_ch ();

  nearest_center_weighted_cost_core #(
    .MAX_CENTERS(MAX_CENTERS),
    .MAX_DIMS   (MAX_DIMS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  nccw_cost_checker #(
    .MAX_CENTERS(MAX_CENTERS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .results_pending_o(results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #(40_000_000);
    $display("tb_nearest_center_weighted_cost_core failed");
    $finish;
  end

  // Result receiver: switch between stall patterns on random stretches; stay
  // open while the streaming run goes through.
  initial begin : receiver
    rx_mode_e rx_mode;
    int       rx_left;
    int       rx_tick;
    logic     rdy;
    rx_mode = RX_OPEN;
    rx_left = 0;
    rx_tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 200);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   rdy = 1'b1;
        RX_COIN:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = ($urandom_range(0, 7) == 0);
        default:   rdy = ((rx_tick % 5) < 2);
      endcase
      out_ch.ready <= fast_mode ? 1'b1 : rdy;
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 4));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int clamp_count(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // Drive one input transaction; open a new burst after an idle gap when the
  // previous one ran out, and drop valid only where a gap follows.
  task automatic send_item(nccw_cmd_e c, logic [CIDX_W-1:0] ci, logic [DIDX_W-1:0] di,
                           logic [COORD_W-1:0] v, logic [WEIGHT_W-1:0] w, logic lp);
    if (burst_left == 0) begin
      repeat (gap_left) @(posedge clk_i);
      burst_left = fast_mode ? 1_000_000 : $urandom_range(1, 16);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= c;
    in_ch.center_index <= ci;
    in_ch.coord_index  <= di;
    in_ch.coord_value  <= v;
    in_ch.point_weight <= w;
    in_ch.last_point   <= lp;
    in_valid_hi = 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    burst_left--;
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      in_valid_hi = 1'b0;
    end
  endtask

  // Drop valid, wait for every expected result, then let the core finish any
  // coordinate that produces no result.
  task automatic settle();
    if (in_valid_hi) begin
      in_ch.valid <= 1'b0;
      in_valid_hi = 1'b0;
    end
    burst_left = 0;
    gap_left   = 0;
    @(negedge clk_i);
    while (results_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transaction: setup, then access until pready. psel stays high so
  // accesses can run back to back; the caller releases it.
  task automatic reg_access(bit wr, nccw_reg_e r, logic [APB_DW-1:0] val);
    psel   <= 1'b1;
    pwrite <= wr;
    paddr  <= {r, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    penable <= 1'b0;
  endtask

  // Write both registers in random order with junk in the unused bits, read
  // them back, and track the clamped values for the stimulus.
  task automatic apply_config(logic [NCFG_W-1:0] nc, logic [NDIM_W-1:0] nd);
    logic [APB_DW-1:0] cw, dw;
    cw = $urandom;
    cw[NCFG_W-1:0] = nc;
    dw = $urandom;
    dw[NDIM_W-1:0] = nd;
    if ($urandom_range(0, 1)) begin
      reg_access(1'b1, REG_ACTIVE_CENTERS, cw);
      reg_access(1'b1, REG_ACTIVE_DIMS, dw);
    end else begin
      reg_access(1'b1, REG_ACTIVE_DIMS, dw);
      reg_access(1'b1, REG_ACTIVE_CENTERS, cw);
    end
    reg_access(1'b0, REG_ACTIVE_CENTERS, '0);
    reg_access(1'b0, REG_ACTIVE_DIMS, '0);
    psel <= 1'b0;
    act_centers = clamp_count(int'(nc), MAX_CENTERS);
    act_dims    = clamp_count(int'(nd), MAX_DIMS);
  endtask

  initial begin : stimulus
    int   c, k, len, pick, phase, quota, random_items;
    logic [COORD_W-1:0] cv;
    random_items = 0;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= CMD_LOAD;
    in_ch.center_index <= '0;
    in_ch.coord_index  <= '0;
    in_ch.coord_value  <= '0;
    in_ch.point_weight <= '0;
    in_ch.last_point   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole store under the reset setting (8 centers, 16 dims) so no
    // later point reads an unwritten entry. Center 0 sits at the positive
    // extreme on every axis, center 1 at the negative one.
    for (c = 0; c < MAX_CENTERS; c++) begin
      for (k = 0; k < MAX_DIMS; k++) begin
        cv = (c == 0) ? 16'h7FFF : ((c == 1) ? 16'h8000 : rand_coord());
        send_item(CMD_LOAD, CIDX_W'(c), DIDX_W'(k), cv, 16'($urandom), 1'($urandom));
      end
    end
    settle();

    // Out-of-range registers: centers 15 clamps to 8, dims 0 clamps to 1, so
    // every coordinate 0 is final and anything past it is ignored.
    apply_config(4'd15, 5'd0);
    send_item(CMD_POINT, 3'd0, 4'd0, 16'h7FFF, 16'hFFFF, 1'b0);
    send_item(CMD_POINT, 3'd7, 4'd0, 16'h8000, 16'h0000, 1'b0);
    send_item(CMD_POINT, 3'd2, 4'd9, rand_coord(), 16'hFFFF, 1'b1);
    send_item(CMD_LOAD, 3'd4, 4'd3, rand_coord(), 16'h0000, 1'b0);
    send_item(CMD_POINT, 3'd0, 4'd0, 16'h0000, 16'h0001, 1'b1);
    settle();

    // Centers 0 clamps to 1, dims 31 to 16: repeat coordinate 0 at maximum
    // distance from center 0, then close the point, which saturates its sum.
    apply_config(4'd0, 5'd31);
    repeat (MAX_DIMS)
      send_item(CMD_POINT, 3'($urandom), 4'd0, 16'h8000, rand_weight(), 1'($urandom));
    send_item(CMD_POINT, 3'd0, 4'd15, 16'h8000, 16'hFFFF, 1'b1);
    settle();

    // Tie between two centers goes to the lower index; a load beyond the
    // active centers is still stored.
    apply_config(4'd2, 5'd1);
    send_item(CMD_LOAD, 3'd0, 4'd0, 16'd100, 16'h0000, 1'b0);
    send_item(CMD_LOAD, 3'd1, 4'd0, 16'd300, 16'hFFFF, 1'b1);
    send_item(CMD_LOAD, 3'd5, 4'd0, 16'hFFF9, 16'h0000, 1'b0);
    send_item(CMD_POINT, 3'd0, 4'd0, 16'd200, 16'd3, 1'b0);
    send_item(CMD_POINT, 3'd0, 4'd0, 16'h8000, 16'hFFFF, 1'b1);
    settle();

    // Random phases: first walk the register extremes, then random settings
    // leaning toward short points. Mostly well-formed points, plus center
    // reloads, scrambled points and ignored items.
    for (phase = 0; random_items < RANDOM_ITEMS; phase++) begin
      if (phase < 4)
        apply_config(EDGE_CENTERS[phase], EDGE_DIMS[phase]);
      else
        apply_config(4'($urandom_range(0, 15)),
                     $urandom_range(0, 1) ? 5'($urandom_range(1, 6))
                                          : 5'($urandom_range(0, 31)));
      quota = random_items + $urandom_range(60, 140);
      while (random_items < quota) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          // well-formed point, weight and end marker matter only at the end
          for (k = 0; k < act_dims; k++)
            send_item(CMD_POINT, 3'($urandom), DIDX_W'(k), rand_coord(), rand_weight(),
                      ($urandom_range(0, 4) == 0));
          random_items += act_dims;
        end else if (pick < 80) begin
          k = $urandom_range(0, MAX_DIMS - 1);
          send_item(CMD_LOAD, 3'($urandom), DIDX_W'(k), rand_coord(), 16'($urandom),
                    1'($urandom));
          if (k < act_dims) random_items++;
        end else if (pick < 92) begin
          // scrambled point: repeats, gaps, out of order, maybe no final
          len = $urandom_range(1, act_dims + 2);
          repeat (len) begin
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_DIMS - 1)
                                            : $urandom_range(0, act_dims - 1);
            send_item(CMD_POINT, 3'($urandom), DIDX_W'(k), rand_coord(), rand_weight(),
                      1'($urandom));
            if (k < act_dims) random_items++;
          end
        end else if (act_dims < MAX_DIMS) begin
          k = $urandom_range(act_dims, MAX_DIMS - 1);
          send_item(nccw_cmd_e'($urandom_range(0, 1)), 3'($urandom), DIDX_W'(k),
                    rand_coord(), 16'($urandom), 1'($urandom));
        end
      end
      settle();
    end

    // Stream points at maximum distance and full weight without idling: one
    // center at the positive extreme, points at the negative one. The last
    // point ends the set and clears the total.
    apply_config(4'd1, 5'd16);
    fast_mode = 1'b1;
    for (k = 0; k < MAX_DIMS; k++)
      send_item(CMD_LOAD, 3'd0, DIDX_W'(k), 16'h7FFF, 16'h0000, 1'b0);
    for (c = 0; c < STREAM_POINTS; c++)
      for (k = 0; k < MAX_DIMS; k++)
        send_item(CMD_POINT, 3'($urandom), DIDX_W'(k), 16'h8000, 16'hFFFF,
                  (c == STREAM_POINTS - 1));
    fast_mode = 1'b0;
    settle();

    if (mismatch_count == 0) begin
      $display("tb_nearest_center_weighted_cost_core passed");
    end else begin
      $display("tb_nearest_center_weighted_cost_core failed");
    end
    $finish;
  end

endmodule
